/* design/pscm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pscm_pkg
// Shared types, codes, widths and helpers for the pen-to-screen mapper core.
// ----------------------------------------------------------------------------
package pscm_pkg;

  // fraction bits of the rotation coefficients (Q2.14)
  localparam int COEFF_FRAC_BITS = 14;

  // datapath widths
  localparam int ROT_W  = 40;  // rotated point, COEFF_FRAC_BITS fraction bits
  localparam int MA_W   = 40;  // multiplier operand A
  localparam int MB_W   = 24;  // multiplier operand B
  localparam int PROD_W = 64;  // registered product
  localparam int DIST_W = 23;  // distance outside an area, whole units
  localparam int SQ_W   = 47;  // sum of two squared distances
  localparam int DIV_W  = 56;  // divider dividend magnitude
  localparam int DEN_W  = 18;  // divider divisor
  localparam int AXV_W  = 57;  // signed axis value, 16 fraction bits
  localparam int MCNT_W = 5;   // map counter, holds up to 31
  localparam int APB_AW = 4;

  localparam logic signed [AXV_W-1:0] ONE_Q16 = AXV_W'(65536);

  // request codes
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_MAP  = 1'b1;

  // table word selects
  localparam logic [3:0] WS_CX = 4'd0;
  localparam logic [3:0] WS_CY = 4'd1;
  localparam logic [3:0] WS_TW = 4'd2;
  localparam logic [3:0] WS_TH = 4'd3;
  localparam logic [3:0] WS_M0 = 4'd4;
  localparam logic [3:0] WS_M1 = 4'd5;
  localparam logic [3:0] WS_M2 = 4'd6;
  localparam logic [3:0] WS_M3 = 4'd7;
  localparam logic [3:0] WS_SW = 4'd8;
  localparam logic [3:0] WS_SH = 4'd9;

  // configuration register indexes
  localparam logic [1:0] REG_MAP_COUNT = 2'd0;
  localparam logic [1:0] REG_VWIDTH    = 2'd1;
  localparam logic [1:0] REG_VHEIGHT   = 2'd2;

  typedef enum logic [4:0] {
    S_IDLE,
    S_ROT0, S_ROT1, S_ROT2, S_ROT3, S_ROT4,
    S_TEST,
    S_DIST0, S_DIST1, S_DIST2,
    S_AX_MUL, S_AX_LD1, S_AX_DIV1, S_AX_SCALE, S_AX_LD2, S_AX_DIV2, S_AX_DONE
  } state_t;

  // amount a rotated coordinate lies outside 0..lim, whole units
  function automatic logic [DIST_W-1:0] outside_dist(
    input logic signed [ROT_W-1:0] p,
    input logic signed [ROT_W-1:0] lim
  );
    logic signed [ROT_W-1:0] e;
    logic [ROT_W-1:0] s;
    e = '0;
    if (p < 0) begin
      e = -p;
    end else if (p > lim) begin
      e = p - lim;
    end
    s = e >> COEFF_FRAC_BITS;
    return s[DIST_W-1:0];
  endfunction

endpackage

/* design/multi_area_pen_to_screen_mapper_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_area_pen_to_screen_mapper_core
// Maps pen positions to normalized virtual screen positions over up to
// MAX_MAPS rotated tablet areas, with one shared multiplier and one divider.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken when start is high and busy is low. in_cmd = load
//   writes one map table word in that same edge and gives no result; busy
//   stays low. in_cmd = map raises busy until the result is out.
//   Each map visited uses the shared multiplier for four rotation products
//   and two squared distances; a map that holds the point stops the walk
//   before its distances. Each axis then takes one product, two 56-step
//   restoring divisions and load, scale and store steps (the first division
//   is skipped when that tablet size is zero). Busy stays high longer the
//   more maps are visited; the divisions take most of that time.
//   The result stands on the out_ ports for one cycle with out_valid high,
//   in the cycle in which busy falls; the receiver cannot stall it.
//   Registers on the APB port: map_count (0x0), virtual_width (0x4),
//   virtual_height (0x8); write them only while busy is low.
//   Reset (rst_n low, synchronous) returns to idle and sets the registers to
//   1, 1920 and 1080; the map table is not cleared and must be loaded.
// ----------------------------------------------------------------------------
module multi_area_pen_to_screen_mapper_core #(
  parameter int MAX_MAPS = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // request channel
  input  logic                                start,
  output logic                                busy,
  input  logic                                in_cmd,
  input  logic [2:0]                          in_map_index,
  input  logic [3:0]                          in_word_select,
  input  logic signed [18:0]                  in_load_value,
  input  logic signed [15:0]                  in_offset_x,
  input  logic signed [15:0]                  in_offset_y,
  input  logic [17:0]                         in_pen_x,
  input  logic [17:0]                         in_pen_y,
  // result channel
  output logic                                out_valid,
  output logic signed [17:0]                  out_norm_x,
  output logic signed [17:0]                  out_norm_y,
  output logic [2:0]                          out_chosen_map,
  output logic                                out_inside_area,
  // configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [pscm_pkg::APB_AW-1:0]         paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);
  import pscm_pkg::*;

  localparam int IDX_W = (MAX_MAPS > 1) ? $clog2(MAX_MAPS) : 1;

  // configuration registers
  logic [3:0]  map_count_r;
  logic [13:0] vwidth_r;
  logic [13:0] vheight_r;

  // map table
  logic [17:0] tcx_mem [MAX_MAPS];
  logic [17:0] tcy_mem [MAX_MAPS];
  logic [17:0] tw_mem  [MAX_MAPS];
  logic [17:0] th_mem  [MAX_MAPS];
  logic [15:0] rot_mem [MAX_MAPS][4];
  logic [13:0] sw_mem  [MAX_MAPS];
  logic [13:0] sh_mem  [MAX_MAPS];
  logic [15:0] ox_mem  [MAX_MAPS];
  logic [15:0] oy_mem  [MAX_MAPS];

  // sequencer and datapath registers
  state_t state_r, state_nxt;
  logic [MCNT_W-1:0]       map_i_r;
  logic [MCNT_W-1:0]       best_r;
  logic                    found_r;
  logic                    inside_r;
  logic [17:0]             px_r, py_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ROT_W-1:0] rx_r, ry_r, bx_r, by_r;
  logic [DIST_W-1:0]       ex_r, ey_r;
  logic [SQ_W-1:0]         d_r, bestd_r;
  logic [17:0]             btw_r, bth_r;
  logic [13:0]             bsw_r, bsh_r;
  logic [15:0]             box_r, boy_r;
  logic                    ax_y_r;
  logic signed [AXV_W-1:0] axv_r;
  logic [DIV_W-1:0]        quo_r;
  logic [DEN_W-1:0]        rem_r, den_r;
  logic                    neg_r;
  logic [5:0]              dcnt_r;
  logic                    out_valid_r;
  logic signed [17:0]      nx_r, ny_r;

  logic load_acc, map_acc, cfg_wr;
  logic [MCNT_W-1:0] idx_ext, last_map, n_eff;
  logic [IDX_W-1:0]  wr_idx, rd_idx;

  assign load_acc = start && !busy && (in_cmd == CMD_LOAD);
  assign map_acc  = start && !busy && (in_cmd == CMD_MAP);
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign idx_ext  = MCNT_W'(in_map_index);
  assign wr_idx   = idx_ext[IDX_W-1:0];
  assign rd_idx   = map_i_r[IDX_W-1:0];

  // effective map count: 0 acts as 1, capped at MAX_MAPS
  always_comb begin
    n_eff = MCNT_W'(map_count_r);
    if (n_eff == '0) begin
      n_eff = MCNT_W'(1);
    end else if (n_eff > MCNT_W'(MAX_MAPS)) begin
      n_eff = MCNT_W'(MAX_MAPS);
    end
    last_map = n_eff - MCNT_W'(1);
  end

  // APB registers
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_count_r <= 4'd1;
      vwidth_r    <= 14'd1920;
      vheight_r   <= 14'd1080;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_MAP_COUNT: map_count_r <= pwdata[3:0];
        REG_VWIDTH:    vwidth_r    <= pwdata[13:0];
        REG_VHEIGHT:   vheight_r   <= pwdata[13:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_MAP_COUNT: prdata = 32'(map_count_r);
      REG_VWIDTH:    prdata = 32'(vwidth_r);
      REG_VHEIGHT:   prdata = 32'(vheight_r);
      default:       prdata = '0;
    endcase
  end

  // table word writes; indexes of MAX_MAPS and above are dropped
  always_ff @(posedge clk) begin
    if (load_acc && (idx_ext < MCNT_W'(MAX_MAPS))) begin
      case (in_word_select)
        WS_CX: tcx_mem[wr_idx] <= in_load_value[17:0];
        WS_CY: tcy_mem[wr_idx] <= in_load_value[17:0];
        WS_TW: tw_mem[wr_idx]  <= in_load_value[17:0];
        WS_TH: th_mem[wr_idx]  <= in_load_value[17:0];
        WS_M0: rot_mem[wr_idx][0] <= in_load_value[15:0];
        WS_M1: rot_mem[wr_idx][1] <= in_load_value[15:0];
        WS_M2: rot_mem[wr_idx][2] <= in_load_value[15:0];
        WS_M3: rot_mem[wr_idx][3] <= in_load_value[15:0];
        WS_SW: begin
          sw_mem[wr_idx] <= in_load_value[13:0];
          ox_mem[wr_idx] <= in_offset_x;
        end
        WS_SH: begin
          sh_mem[wr_idx] <= in_load_value[13:0];
          oy_mem[wr_idx] <= in_offset_y;
        end
        default: ;
      endcase
    end
  end

  // current map's words
  logic signed [18:0]       dx, dy;
  logic signed [ROT_W-1:0]  wl, hl, half_w, half_h;
  assign dx     = $signed({1'b0, px_r}) - $signed({1'b0, tcx_mem[rd_idx]});
  assign dy     = $signed({1'b0, py_r}) - $signed({1'b0, tcy_mem[rd_idx]});
  assign wl     = $signed(ROT_W'(tw_mem[rd_idx]) << COEFF_FRAC_BITS);
  assign hl     = $signed(ROT_W'(th_mem[rd_idx]) << COEFF_FRAC_BITS);
  assign half_w = $signed(ROT_W'(tw_mem[rd_idx]) << (COEFF_FRAC_BITS - 1));
  assign half_h = $signed(ROT_W'(th_mem[rd_idx]) << (COEFF_FRAC_BITS - 1));

  // selected axis operands
  logic signed [ROT_W-1:0] ax_p;
  logic [17:0]             ax_ts;
  logic [13:0]             ax_ss;
  logic [15:0]             ax_off;
  logic [13:0]             ax_vs;
  assign ax_p   = ax_y_r ? by_r  : bx_r;
  assign ax_ts  = ax_y_r ? bth_r : btw_r;
  assign ax_ss  = ax_y_r ? bsh_r : bsw_r;
  assign ax_off = ax_y_r ? boy_r : box_r;
  assign ax_vs  = ax_y_r ? vheight_r : vwidth_r;

  // shared multiplier operand select
  logic signed [MA_W-1:0] mul_a;
  logic signed [MB_W-1:0] mul_b;
  logic [MB_W-1:0]        ss_scaled;
  assign ss_scaled = MB_W'(ax_ss) << (16 - COEFF_FRAC_BITS);

  always_comb begin
    mul_a = MA_W'(dx);
    mul_b = MB_W'($signed(rot_mem[rd_idx][0]));
    case (state_r)
      S_ROT1: begin
        mul_a = MA_W'(dy);
        mul_b = MB_W'($signed(rot_mem[rd_idx][1]));
      end
      S_ROT2: begin
        mul_a = MA_W'(dx);
        mul_b = MB_W'($signed(rot_mem[rd_idx][2]));
      end
      S_ROT3: begin
        mul_a = MA_W'(dy);
        mul_b = MB_W'($signed(rot_mem[rd_idx][3]));
      end
      S_DIST0: begin
        mul_a = $signed(MA_W'(ex_r));
        mul_b = $signed(MB_W'(ex_r));
      end
      S_DIST1: begin
        mul_a = $signed(MA_W'(ey_r));
        mul_b = $signed(MB_W'(ey_r));
      end
      S_AX_MUL: begin
        mul_a = ax_p;
        mul_b = $signed(ss_scaled);
      end
      default: ;
    endcase
  end

  // inside test and distance for the current map
  logic in_area;
  logic [SQ_W-1:0] d_sum;
  assign in_area = (rx_r >= 0) && (rx_r <= wl) && (ry_r >= 0) && (ry_r <= hl);
  assign d_sum   = d_r + prod_r[SQ_W-1:0];

  // divider source and step
  logic signed [PROD_W-1:0] div_src, div_mag;
  logic [DEN_W:0]           rem_sh;
  logic                     q_bit;
  logic signed [AXV_W-1:0]  q_signed;
  assign div_src  = (state_r == S_AX_LD1) ? prod_r : PROD_W'(axv_r);
  assign div_mag  = div_src[PROD_W-1] ? -div_src : div_src;
  assign rem_sh   = {rem_r, quo_r[DIV_W-1]};
  assign q_bit    = rem_sh >= {1'b0, den_r};
  assign q_signed = neg_r ? -$signed({1'b0, quo_r}) : $signed({1'b0, quo_r});

  // clamp to 1..screen size and add the screen offset
  logic signed [AXV_W-1:0] hi_q, off_q, clamped;
  assign hi_q  = $signed(AXV_W'({ax_ss, 16'b0}));
  assign off_q = $signed({{(AXV_W-32){ax_off[15]}}, ax_off, 16'b0});
  always_comb begin
    clamped = axv_r;
    if (axv_r < ONE_Q16) begin
      clamped = ONE_Q16;
    end else if (axv_r > hi_q) begin
      clamped = hi_q;
    end
  end

  // final cap at +/-1.0
  logic signed [AXV_W-1:0] capped;
  always_comb begin
    capped = q_signed;
    if (q_signed > ONE_Q16) begin
      capped = ONE_Q16;
    end else if (q_signed < -ONE_Q16) begin
      capped = -ONE_Q16;
    end
  end

  // sequencer state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:    if (map_acc) state_nxt = S_ROT0;
      S_ROT0:    state_nxt = S_ROT1;
      S_ROT1:    state_nxt = S_ROT2;
      S_ROT2:    state_nxt = S_ROT3;
      S_ROT3:    state_nxt = S_ROT4;
      S_ROT4:    state_nxt = S_TEST;
      S_TEST:    state_nxt = in_area ? S_AX_MUL : S_DIST0;
      S_DIST0:   state_nxt = S_DIST1;
      S_DIST1:   state_nxt = S_DIST2;
      S_DIST2:   state_nxt = (map_i_r == last_map) ? S_AX_MUL : S_ROT0;
      S_AX_MUL:  state_nxt = S_AX_LD1;
      S_AX_LD1:  state_nxt = (ax_ts == '0) ? S_AX_SCALE : S_AX_DIV1;
      S_AX_DIV1: if (dcnt_r == '0) state_nxt = S_AX_SCALE;
      S_AX_SCALE: state_nxt = S_AX_LD2;
      S_AX_LD2:  state_nxt = S_AX_DIV2;
      S_AX_DIV2: if (dcnt_r == '0) state_nxt = S_AX_DONE;
      S_AX_DONE: state_nxt = ax_y_r ? S_IDLE : S_AX_MUL;
      default:   state_nxt = S_IDLE;
    endcase
  end

  assign busy = (state_r != S_IDLE);

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      map_i_r     <= '0;
      found_r     <= 1'b0;
      inside_r    <= 1'b0;
      ax_y_r      <= 1'b0;
      dcnt_r      <= '0;
    end else begin
      out_valid_r <= (state_r == S_AX_DONE) && ax_y_r;
      case (state_r)
        S_IDLE: begin
          map_i_r  <= '0;
          found_r  <= 1'b0;
          inside_r <= 1'b0;
          ax_y_r   <= 1'b0;
        end
        S_TEST:    if (in_area) inside_r <= 1'b1;
        S_DIST2: begin
          found_r <= 1'b1;
          if (map_i_r != last_map) map_i_r <= map_i_r + MCNT_W'(1);
        end
        S_AX_LD1,
        S_AX_LD2:  dcnt_r <= 6'(DIV_W - 1);
        S_AX_DIV1,
        S_AX_DIV2: dcnt_r <= dcnt_r - 6'd1;
        S_AX_DONE: ax_y_r <= 1'b1;
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    case (state_r)
      S_IDLE: begin
        px_r <= in_pen_x;
        py_r <= in_pen_y;
      end
      S_ROT1: rx_r <= prod_r[ROT_W-1:0] + half_w;
      S_ROT2: rx_r <= rx_r + prod_r[ROT_W-1:0];
      S_ROT3: ry_r <= prod_r[ROT_W-1:0] + half_h;
      S_ROT4: ry_r <= ry_r + prod_r[ROT_W-1:0];
      S_TEST: begin
        ex_r <= outside_dist(rx_r, wl);
        ey_r <= outside_dist(ry_r, hl);
      end
      S_DIST1: d_r <= prod_r[SQ_W-1:0];
      S_AX_LD1,
      S_AX_LD2: begin
        neg_r <= div_src[PROD_W-1];
        quo_r <= div_mag[DIV_W-1:0];
        rem_r <= '0;
        if (state_r == S_AX_LD1) begin
          den_r <= ax_ts;
          axv_r <= ONE_Q16;
        end else begin
          den_r <= (ax_vs == '0) ? DEN_W'(1) : DEN_W'(ax_vs);
        end
      end
      S_AX_DIV1,
      S_AX_DIV2: begin
        rem_r <= q_bit ? DEN_W'(rem_sh - {1'b0, den_r}) : rem_sh[DEN_W-1:0];
        quo_r <= {quo_r[DIV_W-2:0], q_bit};
        if (state_r == S_AX_DIV1 && dcnt_r == '0) begin
          axv_r <= neg_r ? -$signed({1'b0, quo_r[DIV_W-2:0], q_bit})
                         : $signed({1'b0, quo_r[DIV_W-2:0], q_bit});
        end
      end
      S_AX_SCALE: axv_r <= clamped + off_q;
      S_AX_DONE: begin
        if (ax_y_r) ny_r <= capped[17:0];
        else        nx_r <= capped[17:0];
      end
      default: ;
    endcase
    // keep the chosen map's point and sizes
    if ((state_r == S_TEST && in_area) ||
        (state_r == S_DIST2 && (!found_r || d_sum < bestd_r))) begin
      best_r <= map_i_r;
      bx_r   <= rx_r;
      by_r   <= ry_r;
      btw_r  <= tw_mem[rd_idx];
      bth_r  <= th_mem[rd_idx];
      bsw_r  <= sw_mem[rd_idx];
      bsh_r  <= sh_mem[rd_idx];
      box_r  <= ox_mem[rd_idx];
      boy_r  <= oy_mem[rd_idx];
      bestd_r <= d_sum;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_norm_x      = nx_r;
  assign out_norm_y      = ny_r;
  assign out_chosen_map  = best_r[2:0];
  assign out_inside_area = inside_r;

`ifndef SYNTHESIS
  a_out_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy)) else $error("result without a running request");
  a_out_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than one cycle");
  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_norm_x <= 18'sd65536) && (out_norm_x >= -18'sd65536) &&
                  (out_norm_y <= 18'sd65536) && (out_norm_y >= -18'sd65536))
    else $error("normalized output beyond +/-1.0");
  a_map_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> (map_i_r <= last_map)) else $error("map counter past map count");
`endif

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the pen-to-screen mapper core. Loads the map table,
// sets the APB registers through several settings, drives directed and random
// pen positions under varying idle patterns and checks every result against
// typed-in values or an in-bench predictor of the mapping arithmetic.
// ----------------------------------------------------------------------------
module testbench;
  import pscm_pkg::*;

  localparam int NMAPS = 8;

  typedef struct packed {
    logic signed [17:0] nx;
    logic signed [17:0] ny;
    logic [2:0]         map;
    logic               in_area;
  } pos_t;

  typedef struct {
    logic               cmd;
    logic [2:0]         idx;
    logic [3:0]         ws;
    logic signed [18:0] val;
    logic signed [15:0] ox;
    logic signed [15:0] oy;
    logic [17:0]        px;
    logic [17:0]        py;
    logic               known;  // expected result typed in
    pos_t               want;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_cmd = 1'b0;
  logic [2:0] in_map_index = '0;
  logic [3:0] in_word_select = '0;
  logic signed [18:0] in_load_value = '0;
  logic signed [15:0] in_offset_x = '0;
  logic signed [15:0] in_offset_y = '0;
  logic [17:0] in_pen_x = '0;
  logic [17:0] in_pen_y = '0;
  logic out_valid;
  logic signed [17:0] out_norm_x;
  logic signed [17:0] out_norm_y;
  logic [2:0] out_chosen_map;
  logic out_inside_area;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  multi_area_pen_to_screen_mapper_core DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #200ms;
    $display("multi_area_pen_to_screen_mapper_core verification failed");
    $finish;
  end

  // predictor copy of the map table and registers
  logic [17:0] tcx [NMAPS];
  logic [17:0] tcy [NMAPS];
  logic [17:0] tw [NMAPS];
  logic [17:0] th [NMAPS];
  logic [15:0] coef [4*NMAPS];
  logic [13:0] sw [NMAPS];
  logic [13:0] sh [NMAPS];
  logic [15:0] sox [NMAPS];
  logic [15:0] soy [NMAPS];
  logic [3:0]  p_count = 4'd1;
  logic [13:0] p_vw = 14'd1920;
  logic [13:0] p_vh = 14'd1080;

  pos_t pending_pos[$];
  int errors = 0;
  int results_seen = 0;
  int send_idle = 0;

  function automatic longint out_units(longint p, longint lim);
    longint e;
    e = 0;
    if (p < 0) e = -p;
    else if (p > lim) e = p - lim;
    return e >>> COEFF_FRAC_BITS;
  endfunction

  function automatic logic signed [17:0] screen_axis(longint p, logic [17:0] ts,
      logic [13:0] ss, logic [15:0] off, logic [13:0] vs);
    longint v, hi, vd;
    hi = longint'(ss) * 65536;
    vd = (vs == 0) ? 1 : longint'(vs);
    if (ts == 0) v = 65536;
    else v = (p * longint'(ss) * 4) / longint'(ts);
    if (v < 65536) v = 65536;
    else if (v > hi) v = hi;
    v += longint'($signed(off)) * 65536;
    v /= vd;
    if (v > 65536) v = 65536;
    if (v < -65536) v = -65536;
    return v[17:0];
  endfunction

  // table write; loads give no result
  task automatic table_write(row_t r);
    if (r.ws == WS_CX) tcx[r.idx] = r.val[17:0];
    else if (r.ws == WS_CY) tcy[r.idx] = r.val[17:0];
    else if (r.ws == WS_TW) tw[r.idx] = r.val[17:0];
    else if (r.ws == WS_TH) th[r.idx] = r.val[17:0];
    else if (r.ws >= WS_M0 && r.ws <= WS_M3) coef[4*r.idx + (r.ws - WS_M0)] = r.val[15:0];
    else if (r.ws == WS_SW) begin
      sw[r.idx] = r.val[13:0];
      sox[r.idx] = r.ox;
    end else if (r.ws == WS_SH) begin
      sh[r.idx] = r.val[13:0];
      soy[r.idx] = r.oy;
    end
  endtask

  function automatic pos_t map_pen(logic [17:0] pxi, logic [17:0] pyi);
    int n, best;
    longint dx, dy, wl, hl, rx, ry, bx, by, ex, ey, d, bestd;
    logic found, ins;
    pos_t r;
    n = (p_count == 0) ? 1 : (p_count > NMAPS ? NMAPS : p_count);
    best = 0; bx = 0; by = 0; bestd = 0; found = 0; ins = 0;
    for (int i = 0; i < n; i++) begin
      dx = longint'(pxi) - longint'(tcx[i]);
      dy = longint'(pyi) - longint'(tcy[i]);
      wl = longint'(tw[i]) << COEFF_FRAC_BITS;
      hl = longint'(th[i]) << COEFF_FRAC_BITS;
      rx = dx * longint'($signed(coef[4*i])) + dy * longint'($signed(coef[4*i+1])) + wl / 2;
      ry = dx * longint'($signed(coef[4*i+2])) + dy * longint'($signed(coef[4*i+3])) + hl / 2;
      if (rx >= 0 && rx <= wl && ry >= 0 && ry <= hl) begin
        best = i; bx = rx; by = ry; ins = 1;
        break;
      end
      ex = out_units(rx, wl);
      ey = out_units(ry, hl);
      d = ex * ex + ey * ey;
      if (!found || d < bestd) begin
        found = 1; bestd = d; best = i; bx = rx; by = ry;
      end
    end
    r.nx = screen_axis(bx, tw[best], sw[best], sox[best], p_vw);
    r.ny = screen_axis(by, th[best], sh[best], soy[best], p_vh);
    r.map = best[2:0];
    r.in_area = ins;
    return r;
  endfunction

  // result checker
  always @(posedge clk) begin
    pos_t e;
    if (rst_n && out_valid) begin
      results_seen++;
      if (pending_pos.size() == 0) begin
        $error("unexpected result");
        errors++;
      end else begin
        e = pending_pos.pop_front();
        if (out_norm_x !== e.nx) begin
          $error("norm_x exp %0d got %0d", e.nx, out_norm_x); errors++;
        end
        if (out_norm_y !== e.ny) begin
          $error("norm_y exp %0d got %0d", e.ny, out_norm_y); errors++;
        end
        if (out_chosen_map !== e.map) begin
          $error("chosen_map exp %0d got %0d", e.map, out_chosen_map); errors++;
        end
        if (out_inside_area !== e.in_area) begin
          $error("inside_area exp %0d got %0d", e.in_area, out_inside_area); errors++;
        end
      end
    end
  end

  task automatic reg_write(logic [1:0] idx, logic [31:0] v);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= APB_AW'({idx, 2'b00}); pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (idx == REG_MAP_COUNT) p_count = v[3:0];
    else if (idx == REG_VWIDTH) p_vw = v[13:0];
    else if (idx == REG_VHEIGHT) p_vh = v[13:0];
  endtask

  // drain, then let a full map request worth of cycles pass
  task automatic wait_idle();
    int guard;
    guard = 0;
    while (pending_pos.size() != 0 && guard < 10000) begin
      @(posedge clk);
      guard++;
    end
    repeat (9 * NMAPS + 240) @(posedge clk);
  endtask

  // issue one request; start is held across back-to-back requests
  task automatic send(row_t r);
    while (send_idle > 0 && $urandom_range(99, 0) < send_idle) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_cmd <= r.cmd; in_map_index <= r.idx; in_word_select <= r.ws;
    in_load_value <= r.val; in_offset_x <= r.ox; in_offset_y <= r.oy;
    in_pen_x <= r.px; in_pen_y <= r.py;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (r.cmd == CMD_LOAD) table_write(r);
    else pending_pos.push_back(r.known ? r.want : map_pen(r.px, r.py));
  endtask

  function automatic row_t load_row(int m, logic [3:0] ws, int v);
    row_t r;
    r = '{default: '0};
    r.cmd = CMD_LOAD; r.idx = m[2:0]; r.ws = ws; r.val = v[18:0];
    r.ox = 16'($urandom); r.oy = 16'($urandom);
    return r;
  endfunction

  function automatic row_t pen_row(int x, int y);
    row_t r;
    r = '{default: '0};
    r.cmd = CMD_MAP; r.px = x[17:0]; r.py = y[17:0];
    return r;
  endfunction

  // one full map with random content, identity-ish or random rotation
  task automatic load_map(int m, bit full_rand);
    int c;
    send(load_row(m, WS_CX, $urandom_range(262143, 0)));
    send(load_row(m, WS_CY, $urandom_range(262143, 0)));
    send(load_row(m, WS_TW, ($urandom_range(9, 0) == 0) ? 0 : $urandom_range(262143, 0)));
    send(load_row(m, WS_TH, ($urandom_range(9, 0) == 0) ? 0 : $urandom_range(262143, 0)));
    for (int k = 0; k < 4; k++) begin
      if (full_rand) c = $urandom;
      else c = ((k == 0 || k == 3) ? 16384 : 0) + $urandom_range(2000, 0) - 1000;
      send(load_row(m, 4'(WS_M0 + k), c));
    end
    send(load_row(m, WS_SW, ($urandom_range(15, 0) == 0) ? 0 : $urandom_range(16383, 0)));
    send(load_row(m, WS_SH, ($urandom_range(15, 0) == 0) ? 0 : $urandom_range(16383, 0)));
  endtask

  initial begin
    row_t dir[$];
    row_t r;
    int idle_phase[4] = '{0, 68, 0, 31};
    int vsz[4] = '{1, 16383, 1920, 0};
    for (int i = 0; i < NMAPS; i++) begin
      tcx[i] = 0; tcy[i] = 0; tw[i] = 0; th[i] = 0;
      sw[i] = 0; sh[i] = 0; sox[i] = 0; soy[i] = 0;
    end
    for (int i = 0; i < 4 * NMAPS; i++) coef[i] = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: map 0 as identity, 100x100 mm tablet to 1920x1080 screen
    dir.push_back(load_row(0, WS_CX, 12800));
    dir.push_back(load_row(0, WS_CY, 12800));
    dir.push_back(load_row(0, WS_TW, 25600));
    dir.push_back(load_row(0, WS_TH, 25600));
    dir.push_back(load_row(0, WS_M0, 16384));
    dir.push_back(load_row(0, WS_M1, 0));
    dir.push_back(load_row(0, WS_M2, 0));
    dir.push_back(load_row(0, WS_M3, 16384));
    r = load_row(0, WS_SW, 1920); r.ox = 0; dir.push_back(r);
    r = load_row(0, WS_SH, 1080); r.oy = 0; dir.push_back(r);
    // far corner: clamped to full screen, caps at 1.0
    r = pen_row(25600, 25600); r.known = 1; r.want = '{65536, 65536, 0, 1};
    dir.push_back(r);
    // origin: low clamp to 1 pixel -> 65536/1920 and 65536/1080
    r = pen_row(0, 0); r.known = 1; r.want = '{34, 60, 0, 1};
    dir.push_back(r);
    // beyond the area, pen field extremes
    r = pen_row(262143, 262143); r.known = 1; r.want = '{65536, 65536, 0, 0};
    dir.push_back(r);
    dir.push_back(pen_row(12800, 6400));
    // ignored word selects with load value extremes
    dir.push_back(load_row(1, 4'd15, -262144));
    dir.push_back(load_row(1, 4'd10, 262143));
    foreach (dir[i]) send(dir[i]);
    start <= 1'b0;
    wait_idle();

    // fill every map, exercise register extremes and random pens
    for (int m = 0; m < NMAPS; m++) load_map(m, m >= 6);
    start <= 1'b0;
    wait_idle();
    for (int ph = 0; ph < 8; ph++) begin
      reg_write(REG_MAP_COUNT, (ph == 0) ? 0 : (ph == 1 ? 15 : $urandom_range(8, 1)));
      reg_write(REG_VWIDTH, vsz[ph % 4]);
      reg_write(REG_VHEIGHT, vsz[(ph + 1) % 4]);
      send_idle = idle_phase[ph % 4];
      for (int k = 0; k < 197; k++) begin
        if ($urandom_range(19, 0) == 0) begin
          r = load_row($urandom_range(7, 0), 4'($urandom_range(15, 0)), $urandom);
          send(r);
        end else begin
          r = pen_row($urandom_range(262143, 0), $urandom_range(262143, 0));
          if ($urandom_range(1, 0)) begin
            // stay near a loaded center
            r.px = tcx[$urandom_range(7, 0)] + 18'($urandom_range(8000, 0) - 4000);
            r.py = tcy[$urandom_range(7, 0)] + 18'($urandom_range(8000, 0) - 4000);
          end
          send(r);
        end
        if (k == 100 && ph == 2) begin
          start <= 1'b0;
          wait_idle();
        end
      end
      start <= 1'b0;
      wait_idle();
      if (ph == 3) for (int m = 0; m < NMAPS; m++) load_map(m, $urandom_range(1, 0));
      start <= 1'b0;
      wait_idle();
    end

    $display("Covered table loads, ignored words, %0d pen mappings over map counts 0..15",
             results_seen);
    $display("and virtual sizes 0..16383 with several idle patterns.");
    if (errors == 0 && pending_pos.size() == 0) begin
      $display("multi_area_pen_to_screen_mapper_core verification clean");
    end else begin
      $display("multi_area_pen_to_screen_mapper_core verification failed");
    end
    $finish;
  end
endmodule
